// ===== hdl/pbp_pkg.sv =====
`timescale 1ns / 1ps
package pbp_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Request function codes
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // Configuration register indexes
    localparam logic CFG_PARTS = 1'b0;
    localparam logic CFG_BUFS  = 1'b1;

    localparam int COUNT_W    = 7;
    localparam int BUFNUM_W   = 11;
    localparam int FREE_W     = 12;
    localparam int CFG_DATA_W = 9;

    typedef struct packed {
        logic                func;
        logic [COUNT_W-1:0]  count;
        logic [BUFNUM_W-1:0] buffer_number;
    } t_in_req;

    typedef struct packed {
        t_status             status;
        logic [BUFNUM_W-1:0] granted_buffer;
        logic [FREE_W-1:0]   free_total;
        logic                last;
    } t_out_req;

endpackage

// ===== hdl/partitioned_buffer_pool.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Signals                                Carries
// request   in   i_in_valid, o_in_stall, i_in           get of N buffers or put of one
// result    out  o_out_valid, i_out_stall, o_out        one per put, rejected get or granted buffer
// config    in   i_cfg_we, i_cfg_index, i_cfg_data      partition count, buffers each
//
// A put or a rejected get is settled on acceptance; a granted get of N buffers steps
// through S_POP and S_EMIT once per buffer, set by the registered read of the stack RAM.
// A get of zero buffers gives no result.
// On reset a per-partition low-water mark stands in for the identity contents of
// the stacks, so there is no clearing pass.
// A stalled full output or a get in progress stalls requests; a config write refills active stacks.
module partitioned_buffer_pool
    import pbp_pkg::*;
#(
    parameter int MAX_PARTITIONS = 8,
    parameter int MAX_BUFFERS    = 256,
    parameter int MAX_GRANT      = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_req               i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_req              o_out,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PW    = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int LW    = $clog2(MAX_BUFFERS);
    localparam int CW    = $clog2(MAX_PARTITIONS + 1);
    localparam int BW    = $clog2(MAX_BUFFERS + 1);
    localparam int DEPTH = MAX_PARTITIONS * MAX_BUFFERS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int RST_PARTS = (8 > MAX_PARTITIONS) ? MAX_PARTITIONS : 8;
    localparam int RST_BUFS  = (256 > MAX_BUFFERS) ? MAX_BUFFERS : 256;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_piu;
    logic [BW-1:0]      r_bpp;
    logic [BW-1:0]      r_level [MAX_PARTITIONS];
    logic [BW-1:0]      r_lw    [MAX_PARTITIONS];
    logic [FW-1:0]      r_free;
    logic [COUNT_W-1:0] r_remain;
    logic [PW-1:0]      r_pop_part;
    logic [LW-1:0]      r_pop_idx;
    logic               r_pop_id;
    logic               r_out_valid;
    t_out_req           r_out;

    logic [CW-1:0]  n_piu;
    logic [BW-1:0]  n_bpp;
    logic [CW-1:0]  rf_piu;
    logic [BW-1:0]  rf_bpp;
    logic [3:0]     cfg_parts_raw;
    logic           slot_free;
    logic           accept;
    logic           get_short;
    logic           put_hit;
    logic [PW-1:0]  put_part;
    logic [LW-1:0]  put_local;
    logic [BW-1:0]  put_level;
    logic           put_full;
    logic           put_ok;
    logic [PW-1:0]  sel_part;
    logic           any_nz;
    logic [BW-1:0]  pop_lvl;
    logic           load_out;
    t_out_req       n_out;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [LW-1:0]  ram_rdata;
    logic [LW-1:0]  emit_local;

    // Saturate config writes into range
    always_comb begin
        cfg_parts_raw = i_cfg_data[3:0];
        n_piu = r_piu;
        n_bpp = r_bpp;
        if (i_cfg_index == CFG_PARTS) begin
            if (cfg_parts_raw == 4'd0) begin
                n_piu = CW'(1);
            end else if (int'(cfg_parts_raw) > MAX_PARTITIONS) begin
                n_piu = CW'(MAX_PARTITIONS);
            end else begin
                n_piu = CW'(cfg_parts_raw);
            end
        end else begin
            if (i_cfg_data == '0) begin
                n_bpp = BW'(1);
            end else if (int'(i_cfg_data) > MAX_BUFFERS) begin
                n_bpp = BW'(MAX_BUFFERS);
            end else begin
                n_bpp = BW'(i_cfg_data);
            end
        end
        rf_piu = i_rst_n ? n_piu : CW'(RST_PARTS);
        rf_bpp = i_rst_n ? n_bpp : BW'(RST_BUFS);
    end

    pbp_put_decode #(
        .MAX_PARTITIONS(MAX_PARTITIONS),
        .MAX_BUFFERS   (MAX_BUFFERS),
        .PW            (PW),
        .LW            (LW),
        .CW            (CW),
        .BW            (BW)
    ) u_decode (
        .i_buffer_number(i_in.buffer_number),
        .i_piu          (r_piu),
        .i_bpp          (r_bpp),
        .o_hit          (put_hit),
        .o_part         (put_part),
        .o_local        (put_local)
    );

    // First non-empty partition for the next pop
    always_comb begin
        sel_part = '0;
        any_nz   = 1'b0;
        for (int p = MAX_PARTITIONS - 1; p >= 0; p--) begin
            if (r_level[p] != '0) begin
                sel_part = PW'(p);
                any_nz   = 1'b1;
            end
        end
        pop_lvl = r_level[sel_part] - BW'(1);
    end

    // Handshake and request decode
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && slot_free);
    assign accept     = i_in_valid && !o_in_stall;
    assign get_short  = (int'(i_in.count) > MAX_GRANT) || (int'(r_free) < int'(i_in.count));
    assign put_level  = r_level[put_part];
    assign put_full   = put_level >= r_bpp;
    assign put_ok     = accept && (i_in.func == FUNC_PUT) && put_hit && !put_full;

    // Stack RAM: pushes write in the accept cycle, pops read in a later cycle,
    // so a read never overlaps a write to the same entry
    assign ram_we     = put_ok;
    assign ram_waddr  = AW'(int'(put_part) * MAX_BUFFERS + int'(put_level));
    assign ram_re     = (r_state == S_POP);
    assign ram_raddr  = AW'(int'(sel_part) * MAX_BUFFERS + int'(pop_lvl));
    // Entries below the low-water mark were never pushed since refill
    assign emit_local = r_pop_id ? r_pop_idx : ram_rdata;

    pbp_stack_ram #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .DW   (LW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(put_local),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Result selection
    always_comb begin
        load_out = 1'b0;
        n_out    = '{status: ST_OK, granted_buffer: '0, free_total: FREE_W'(r_free),
                     last: 1'b1};
        if (accept) begin
            if (i_in.func == FUNC_GET) begin
                if (i_in.count != '0 && get_short) begin
                    load_out     = 1'b1;
                    n_out.status = ST_SHORT;
                end
            end else begin
                load_out = 1'b1;
                if (!put_hit) begin
                    n_out.status = ST_RANGE;
                end else if (put_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_out.free_total = FREE_W'(r_free + FW'(1));
                end
            end
        end else if (r_state == S_EMIT && slot_free) begin
            load_out             = 1'b1;
            n_out.granted_buffer = BUFNUM_W'(int'(r_pop_part) * MAX_BUFFERS
                                             + int'(emit_local));
            n_out.last           = (r_remain == COUNT_W'(1));
        end
    end

    // Control and stack state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_piu  <= rf_piu;
            r_bpp  <= rf_bpp;
            r_free <= FW'(rf_piu) * FW'(rf_bpp);
            for (int p = 0; p < MAX_PARTITIONS; p++) begin
                r_level[p] <= (p < int'(rf_piu)) ? rf_bpp : '0;
                r_lw[p]    <= rf_bpp;
            end
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_remain    <= '0;
        end else begin
            if (!i_cfg_we) begin
                case (r_state)
                    S_IDLE: begin
                        if (accept && i_in.func == FUNC_GET && i_in.count != '0
                                && !get_short) begin
                            r_remain <= i_in.count;
                            r_state  <= S_POP;
                        end
                        if (put_ok) begin
                            r_level[put_part] <= put_level + BW'(1);
                            r_free            <= r_free + FW'(1);
                            if (put_level < r_lw[put_part]) begin
                                r_lw[put_part] <= put_level;
                            end
                        end
                    end
                    S_POP: begin
                        r_level[sel_part] <= pop_lvl;
                        r_free            <= r_free - FW'(1);
                        r_pop_part        <= sel_part;
                        r_pop_idx         <= LW'(pop_lvl);
                        r_pop_id          <= pop_lvl < r_lw[sel_part];
                        r_state           <= S_EMIT;
                    end
                    S_EMIT: begin
                        if (slot_free) begin
                            r_remain <= r_remain - COUNT_W'(1);
                            r_state  <= (r_remain == COUNT_W'(1)) ? S_IDLE : S_POP;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
            // Output register
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Free count never exceeds the configured pool
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_free) <= int'(r_piu) * int'(r_bpp))
        else $error("free count above pool size");

    // A pop only happens with some partition holding a buffer
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> any_nz)
        else $error("pop with all partitions empty");

    // An accepted push raises the free count by one
    a_put_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (put_ok && !i_cfg_we) |=> (r_free == FW'($past(r_free) + FW'(1))))
        else $error("push did not bump free count");

endmodule

// ===== hdl/pbp_stack_ram.sv =====
`timescale 1ns / 1ps
module pbp_stack_ram
    import pbp_pkg::*;
#(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pbp_put_decode.sv =====
`timescale 1ns / 1ps
module pbp_put_decode
    import pbp_pkg::*;
#(
    parameter int MAX_PARTITIONS = 8,
    parameter int MAX_BUFFERS    = 256,
    parameter int PW             = 3,
    parameter int LW             = 8,
    parameter int CW             = 4,
    parameter int BW             = 9
) (
    input  logic [BUFNUM_W-1:0] i_buffer_number,
    input  logic [CW-1:0]       i_piu,
    input  logic [BW-1:0]       i_bpp,
    output logic                o_hit,
    output logic [PW-1:0]       o_part,
    output logic [LW-1:0]       o_local
);

    logic found;
    int   bn;

    // Window match per partition, then one subtract for the local index
    always_comb begin
        bn     = int'(i_buffer_number);
        found  = 1'b0;
        o_part = '0;
        for (int p = 0; p < MAX_PARTITIONS; p++) begin
            if (bn >= p * MAX_BUFFERS && bn < (p + 1) * MAX_BUFFERS) begin
                found  = 1'b1;
                o_part = PW'(p);
            end
        end
        o_local = LW'(bn - int'(o_part) * MAX_BUFFERS);
        o_hit   = found && (CW'(o_part) < i_piu) && (BW'(o_local) < i_bpp);
    end

endmodule
